// File: src/prc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the polygon rectangle clipper.
package prc_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int FX_W       = COORD_BITS + FRAC_BITS;
    localparam int QW         = FX_W;
    localparam int DEN_W      = FX_W + 1;
    localparam int NUM_W      = 2 * FX_W + 2;
    localparam int PROD_W     = 2 * FX_W;
    localparam int IT_W       = $clog2(QW);
    localparam int NSTAGE     = 4;
    localparam int NLVL       = NSTAGE + 1;
    localparam int LVL_W      = $clog2(NLVL);
    localparam int STG_W      = $clog2(NSTAGE);
    localparam int MAX_OUT    = 16;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);
    localparam int REG_IDX_W  = 2;

    // register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TOP    = 2'd3;

    // clipping stages in cascade order
    localparam logic [STG_W-1:0] STG_LEFT   = 2'd0;
    localparam logic [STG_W-1:0] STG_TOP    = 2'd1;
    localparam logic [STG_W-1:0] STG_RIGHT  = 2'd2;
    localparam logic [STG_W-1:0] STG_BOTTOM = 2'd3;

    localparam logic signed [COORD_BITS-1:0] RST_LEFT   = COORD_BITS'(0);
    localparam logic signed [COORD_BITS-1:0] RST_BOTTOM = COORD_BITS'(0);
    localparam logic signed [COORD_BITS-1:0] RST_RIGHT  = COORD_BITS'(639);
    localparam logic signed [COORD_BITS-1:0] RST_TOP    = COORD_BITS'(479);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [FX_W-1:0]       t_fx;

    typedef struct packed {
        t_fx x;
        t_fx y;
    } t_vtx;

    typedef struct packed {
        logic start;
        t_fx  c1;
        t_fx  c2;
        t_fx  w;
        t_fx  o1;
        t_fx  o2;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_fx  res;
    } t_div_rsp;

    function automatic t_fx to_fix(input t_coord c);
        return {c, {FRAC_BITS{1'b0}}};
    endfunction

    // floor(v + 0.5), wrapped to the coordinate width
    function automatic t_coord round_out(input t_fx v);
        logic signed [FX_W:0] s;
        s = {v[FX_W-1], v} + (FX_W + 1)'(1 << (FRAC_BITS - 1));
        return s[FX_W-1:FRAC_BITS];
    endfunction

endpackage

// File: src/prc_div.sv
`timescale 1ns / 1ps
// Crossing point unit: one multiply, then a restoring divide one bit per cycle.
module prc_div import prc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_MUL  = 5'b00010,
        D_NUM  = 5'b00100,
        D_ITER = 5'b01000,
        D_DONE = 5'b10000
    } t_dstate;

    t_dstate r_st;
    logic [FX_W-1:0]   r_p, r_a, r_d, r_q, r_sh;
    logic              r_neg, r_done;
    t_fx               r_o1, r_res;
    logic [PROD_W-1:0] r_prod;
    logic [DEN_W-1:0]  r_rem;
    logic [IT_W-1:0]   r_it;

    logic signed [FX_W:0] dc, aw, dov;
    logic [FX_W-1:0]      ud, ua, up, qf;
    logic [NUM_W-1:0]     num;
    logic [DEN_W-1:0]     den;
    logic [DEN_W:0]       trial;
    logic                 ge;

    always_comb begin
        dc    = {i_req.c2[FX_W-1], i_req.c2} - {i_req.c1[FX_W-1], i_req.c1};
        aw    = {i_req.w[FX_W-1], i_req.w} - {i_req.c1[FX_W-1], i_req.c1};
        dov   = {i_req.o2[FX_W-1], i_req.o2} - {i_req.o1[FX_W-1], i_req.o1};
        ud    = dc[FX_W] ? FX_W'(-dc) : FX_W'(dc);
        ua    = aw[FX_W] ? FX_W'(-aw) : FX_W'(aw);
        up    = dov[FX_W] ? FX_W'(-dov) : FX_W'(dov);
        // 2*p*a + d, less one when the result heads downwards
        num   = {1'b0, r_prod, 1'b0} + NUM_W'(r_d) - NUM_W'(r_neg);
        den   = {r_d, 1'b0};
        trial = {r_rem, r_sh[FX_W-1]};
        ge    = trial >= {1'b0, den};
        qf    = (r_d == '0) ? '0 : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_p   <= up;
                        r_a   <= ua;
                        r_d   <= ud;
                        r_neg <= dov[FX_W];
                        r_o1  <= i_req.o1;
                        r_st  <= D_MUL;
                    end
                end
                D_MUL: begin
                    r_prod <= r_p * r_a;
                    r_st   <= D_NUM;
                end
                D_NUM: begin
                    r_rem <= num[QW+DEN_W-1:QW];
                    r_sh  <= num[QW-1:0];
                    r_it  <= '0;
                    r_st  <= D_ITER;
                end
                D_ITER: begin
                    r_rem <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
                    r_sh  <= {r_sh[FX_W-2:0], 1'b0};
                    r_q   <= {r_q[FX_W-2:0], ge};
                    if (r_it == IT_W'(QW - 1)) begin
                        r_st <= D_DONE;
                    end else begin
                        r_it <= r_it + 1'b1;
                    end
                end
                D_DONE: begin
                    r_res  <= r_neg ? t_fx'(r_o1 - qf) : t_fx'(r_o1 + qf);
                    r_done <= 1'b1;
                    r_st   <= D_IDLE;
                end
                default: r_st <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// File: src/polygon_rect_clipper_unit.sv
`timescale 1ns / 1ps
// Polygon clipper against a rectangular window, one vertex request at a time.
//
// Vertices enter one request at a time; closing marks the last vertex of a
// polygon. Each vertex passes depth first through four clipping stages (left,
// top, right, bottom); every stage keeps its first and previous vertex in
// Q12.8 and hands at most two vertices to the next stage through a small
// pending buffer. Crossing points come from one shared unit: a 20x20 multiply
// and a restoring divide of one quotient bit per cycle, which holds the
// sequencer until the crossing is done. Every vertex a stage takes in passes
// through pick and test, every result through out and pick, and each request
// ends in flush. A closing request also takes the closing edge of each
// started stage through pick and test, and skips a stage left idle in pick.
// o_ready stays low until the request is through, including any wait on the
// result side. Results are rounded to integers (half up); a polygon with
// nothing left gives one result with o_vertex_valid low and o_polygon_end
// high. At most 16 results are given per request, the 16th carrying the
// polygon end on a closing request. An output register parts the result
// side, so a new request may be taken while a result still waits. Window
// registers are written through the configuration channel; the user must
// write them only while idle, and the block itself does not enforce it.
module polygon_rect_clipper_unit import prc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_vert_x,
    input  logic [COORD_BITS-1:0] i_vert_y,
    input  logic                  i_closing,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic                  o_vertex_valid,
    output logic                  o_polygon_end,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [REG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PICK  = 6'b000010,
        ST_TEST  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_FLUSH = 6'b100000
    } t_state;

    t_state r_state;

    // window
    t_coord r_left, r_bottom, r_right, r_top;

    // per stage polygon state
    t_vtx r_first [NSTAGE];
    t_vtx r_prev  [NSTAGE];
    logic [NSTAGE-1:0] r_started;

    // pending vertices waiting at each level; level NSTAGE feeds the output
    t_vtx       r_pq   [NLVL][2];
    logic [1:0] r_pq_n [NLVL];

    // sequencer context
    logic [STG_W-1:0] r_stg;
    t_vtx             r_cur;
    logic             r_close, r_end, r_push_b;
    logic [STG_W:0]   r_cls;

    // result hold and output register
    t_vtx             r_hold;
    logic             r_hold_v;
    logic [CNT_W-1:0] r_cnt;
    logic             r_o_valid, r_o_vv, r_o_end;
    t_coord           r_o_x, r_o_y;

    logic             lv_hit;
    logic [STG_W-1:0] lv_sel;
    t_vtx             pa;
    t_fx              wfix;
    logic             ia, ib, out_free;
    logic [LVL_W-1:0] lvl_n;
    t_vtx             xpt;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    prc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        // deepest stage with work waiting goes first
        lv_hit = 1'b0;
        lv_sel = '0;
        for (int s = 0; s < NSTAGE; s++) begin
            if (r_pq_n[s] != 2'd0) begin
                lv_hit = 1'b1;
                lv_sel = STG_W'(s);
            end
        end

        pa = r_prev[r_stg];
        case (r_stg)
            STG_LEFT: begin
                wfix = to_fix(r_left);
                ia   = pa.x >= wfix;
                ib   = r_cur.x >= wfix;
            end
            STG_TOP: begin
                wfix = to_fix(r_top);
                ia   = pa.y <= wfix;
                ib   = r_cur.y <= wfix;
            end
            STG_RIGHT: begin
                wfix = to_fix(r_right);
                ia   = pa.x <= wfix;
                ib   = r_cur.x <= wfix;
            end
            default: begin
                wfix = to_fix(r_bottom);
                ia   = pa.y >= wfix;
                ib   = r_cur.y >= wfix;
            end
        endcase

        // left and right clip x, top and bottom clip y
        div_req.start = (r_state == ST_TEST) && r_started[r_stg] && (ia != ib);
        div_req.w     = wfix;
        if (!r_stg[0]) begin
            div_req.c1 = pa.x;
            div_req.c2 = r_cur.x;
            div_req.o1 = pa.y;
            div_req.o2 = r_cur.y;
            xpt.x      = wfix;
            xpt.y      = div_rsp.res;
        end else begin
            div_req.c1 = pa.y;
            div_req.c2 = r_cur.y;
            div_req.o1 = pa.x;
            div_req.o2 = r_cur.x;
            xpt.x      = div_rsp.res;
            xpt.y      = wfix;
        end

        lvl_n    = LVL_W'(r_stg) + 1'b1;
        out_free = !r_o_valid || i_ready;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= RST_LEFT;
            r_bottom <= RST_BOTTOM;
            r_right  <= RST_RIGHT;
            r_top    <= RST_TOP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                default:    r_left   <= r_left;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= '0;
            for (int l = 0; l < NLVL; l++) begin
                r_pq_n[l] <= 2'd0;
            end
            r_hold_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // drop the output request once taken
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_pq[0][0] <= '{x: to_fix(i_vert_x), y: to_fix(i_vert_y)};
                        r_pq_n[0]  <= 2'd1;
                        r_end      <= i_closing;
                        r_cls      <= '0;
                        r_cnt      <= '0;
                        r_state    <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    if (r_pq_n[NSTAGE] != 2'd0) begin
                        r_state <= ST_OUT;
                    end else if (lv_hit) begin
                        r_stg   <= lv_sel;
                        r_cur   <= r_pq[LVL_W'(lv_sel)][0];
                        r_pq[LVL_W'(lv_sel)][0] <= r_pq[LVL_W'(lv_sel)][1];
                        r_pq_n[LVL_W'(lv_sel)]  <= r_pq_n[LVL_W'(lv_sel)] - 1'b1;
                        r_close <= 1'b0;
                        r_state <= ST_TEST;
                    end else if (r_end && (r_cls != (STG_W + 1)'(NSTAGE))) begin
                        // close stages in cascade order, each after deeper work drains
                        r_cls <= r_cls + 1'b1;
                        if (r_started[r_cls[STG_W-1:0]]) begin
                            r_stg   <= r_cls[STG_W-1:0];
                            r_cur   <= r_first[r_cls[STG_W-1:0]];
                            r_close <= 1'b1;
                            r_state <= ST_TEST;
                        end
                    end else begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_TEST: begin
                    if (!r_started[r_stg]) begin
                        r_started[r_stg] <= 1'b1;
                        r_first[r_stg]   <= r_cur;
                        r_prev[r_stg]    <= r_cur;
                        r_state          <= ST_PICK;
                    end else begin
                        if (r_close) begin
                            r_started[r_stg] <= 1'b0;
                        end else begin
                            r_prev[r_stg] <= r_cur;
                        end
                        r_push_b <= ib;
                        case ({ia, ib})
                            2'b11: begin
                                r_pq[lvl_n][0] <= r_cur;
                                r_pq_n[lvl_n]  <= 2'd1;
                                r_state        <= ST_PICK;
                            end
                            2'b01, 2'b10: r_state <= ST_DIV;
                            default:      r_state <= ST_PICK;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_pq[lvl_n][0] <= xpt;
                        r_pq[lvl_n][1] <= r_cur;
                        r_pq_n[lvl_n]  <= r_push_b ? 2'd2 : 2'd1;
                        r_state        <= ST_PICK;
                    end
                end
                ST_OUT: begin
                    // hold one result back so the last one can carry the end flag
                    if (r_cnt == CNT_W'(MAX_OUT)) begin
                        r_pq[NSTAGE][0] <= r_pq[NSTAGE][1];
                        r_pq_n[NSTAGE]  <= r_pq_n[NSTAGE] - 1'b1;
                        r_state         <= ST_PICK;
                    end else if (!r_hold_v || out_free) begin
                        if (r_hold_v) begin
                            r_o_valid <= 1'b1;
                            r_o_x     <= round_out(r_hold.x);
                            r_o_y     <= round_out(r_hold.y);
                            r_o_vv    <= 1'b1;
                            r_o_end   <= 1'b0;
                        end
                        r_hold          <= r_pq[NSTAGE][0];
                        r_hold_v        <= 1'b1;
                        r_cnt           <= r_cnt + 1'b1;
                        r_pq[NSTAGE][0] <= r_pq[NSTAGE][1];
                        r_pq_n[NSTAGE]  <= r_pq_n[NSTAGE] - 1'b1;
                        r_state         <= ST_PICK;
                    end
                end
                ST_FLUSH: begin
                    if (r_hold_v) begin
                        if (out_free) begin
                            r_o_valid <= 1'b1;
                            r_o_x     <= round_out(r_hold.x);
                            r_o_y     <= round_out(r_hold.y);
                            r_o_vv    <= 1'b1;
                            r_o_end   <= r_end;
                            r_hold_v  <= 1'b0;
                            r_state   <= ST_IDLE;
                        end
                    end else if (r_end) begin
                        // nothing survived the close: send the empty marker
                        if (out_free) begin
                            r_o_valid <= 1'b1;
                            r_o_x     <= '0;
                            r_o_y     <= '0;
                            r_o_vv    <= 1'b0;
                            r_o_end   <= 1'b1;
                            r_state   <= ST_IDLE;
                        end
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_o_valid;
    assign o_out_x        = r_o_x;
    assign o_out_y        = r_o_y;
    assign o_vertex_valid = r_o_vv;
    assign o_polygon_end  = r_o_end;

endmodule

// File: src/prc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the polygon clipper, bound to the top level.
module prc_checker import prc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic [COORD_BITS-1:0] i_vert_x,
    input logic [COORD_BITS-1:0] i_vert_y,
    input logic                  i_closing,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [COORD_BITS-1:0] o_out_x,
    input logic [COORD_BITS-1:0] o_out_y,
    input logic                  o_vertex_valid,
    input logic                  o_polygon_end,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [REG_IDX_W-1:0]  i_cfg_index,
    input logic [COORD_BITS-1:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_vertex_valid) && $stable(o_polygon_end))
        else $error("stalled result changed");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_vertex_valid |-> o_polygon_end && o_out_x == '0 && o_out_y == '0)
        else $error("empty marker malformed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after request accepted");

    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && !o_valid |=> !o_valid || !o_ready || $past(i_valid))
        else $error("result appeared without a request");

endmodule

bind polygon_rect_clipper_unit prc_checker u_prc_checker (.*);
